@@ hw/rtl/mecanum_inverse_kinematics_limiter_unit_macros.svh @@
// Assertion macros for the mecanum inverse kinematics limiter.
`ifndef MECANUM_INVERSE_KINEMATICS_LIMITER_UNIT_MACROS_SVH
`define MECANUM_INVERSE_KINEMATICS_LIMITER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MIKL_ASSERT_IMPLIES(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) else $error(msg);
`define MIKL_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error(msg);
`else
`define MIKL_ASSERT_IMPLIES(lbl, a, b, msg)
`define MIKL_ASSERT_NEXT(lbl, a, b, msg)
`endif
`endif

@@ hw/rtl/mikl_pkg.sv @@
// Shared types and constants of the mecanum inverse kinematics limiter.
package mikl_pkg;
  localparam int unsigned CmdW      = 32;
  localparam int unsigned CfgW      = 31;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned MagW      = 48;
  localparam int unsigned AbsW      = 49;
  localparam int unsigned NumW      = 50;
  localparam int unsigned RemW      = 32;
  localparam int unsigned ScaleW    = 16;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WHEEL_DIA        = 3'd0,
    REG_HALF_LENGTH      = 3'd1,
    REG_HALF_WIDTH       = 3'd2,
    REG_LIMIT_VX         = 3'd3,
    REG_LIMIT_VY         = 3'd4,
    REG_LIMIT_WZ         = 3'd5,
    REG_LIMIT_WHEEL_RATE = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CmdW-1:0] cmd_vx;
    logic signed [CmdW-1:0] cmd_vy;
    logic signed [CmdW-1:0] cmd_wz;
  } cmd_t;

  typedef struct packed {
    logic signed [CmdW-1:0] rate_front_left;
    logic signed [CmdW-1:0] rate_front_right;
    logic signed [CmdW-1:0] rate_back_left;
    logic signed [CmdW-1:0] rate_back_right;
  } rate_t;

  typedef struct packed {
    logic [CfgW-1:0] wheel_dia;
    logic [CfgW-1:0] half_length;
    logic [CfgW-1:0] half_width;
    logic [CfgW-1:0] limit_vx;
    logic [CfgW-1:0] limit_vy;
    logic [CfgW-1:0] limit_wz;
    logic [CfgW-1:0] limit_wheel_rate;
  } cfg_t;

  // Clamped command plus the all-zero class bit.
  typedef struct packed {
    cmd_t cmd;
    logic zero;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;
endpackage

@@ hw/rtl/mecanum_inverse_kinematics_limiter_unit.sv @@
// Top level of the mecanum inverse kinematics limiter.
// Usage:
//   Command channel: an item (vx, vy, wz) is taken when start is high and
//   busy is low. busy rises only while the two-item queue is full.
//   Result channel: result_valid_o is high for one cycle with the four wheel
//   rates on result_o; the receiver cannot stall, so take it then.
//   Config channel: cfg_valid_i with cfg_index_i and cfg_data_i; cfg_ready_o
//   is always high. Write only while the block is idle.
// Sequence: an all-zero command gets a zero result straight from idle.
// Other commands pass through KW, NUM and DIV, then MAX; when the wheel
// limit is hit, SDIV and SCALE rescale the commands and KW, NUM and DIV run
// again before DONE. DIV is the four-lane divider of the back part, 2
// quotient bits a cycle over 48 bits. The back part takes a new item only
// when idle, while the queue takes the next ones.
// Reset: the queue empties, the sequencer idles and the registers take
// their defaults (diameter 1.0, limits 1.0, wheel limit 10.0).
`include "mecanum_inverse_kinematics_limiter_unit_macros.svh"
module mecanum_inverse_kinematics_limiter_unit import mikl_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  cmd_t               cmd_i,
  output logic               busy,
  output logic               result_valid_o,
  output rate_t              result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);
  cfg_t    cfg_q;
  q_stat_t q_stat;
  job_t    push_job, pop_job;
  logic    q_push, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wheel_dia        <= CfgW'(65536);
      cfg_q.half_length      <= '0;
      cfg_q.half_width       <= '0;
      cfg_q.limit_vx         <= CfgW'(65536);
      cfg_q.limit_vy         <= CfgW'(65536);
      cfg_q.limit_wz         <= CfgW'(65536);
      cfg_q.limit_wheel_rate <= CfgW'(655360);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_WHEEL_DIA:        cfg_q.wheel_dia        <= cfg_data_i;
        REG_HALF_LENGTH:      cfg_q.half_length      <= cfg_data_i;
        REG_HALF_WIDTH:       cfg_q.half_width       <= cfg_data_i;
        REG_LIMIT_VX:         cfg_q.limit_vx         <= cfg_data_i;
        REG_LIMIT_VY:         cfg_q.limit_vy         <= cfg_data_i;
        REG_LIMIT_WZ:         cfg_q.limit_wz         <= cfg_data_i;
        REG_LIMIT_WHEEL_RATE: cfg_q.limit_wheel_rate <= cfg_data_i;
        default:              cfg_q <= cfg_q;
      endcase
    end
  end

  mikl_front u_front (
    .start_i (start),
    .cmd_i   (cmd_i),
    .cfg_i   (cfg_q),
    .full_i  (q_stat.full),
    .busy_o  (busy),
    .push_o  (q_push),
    .job_o   (push_job)
  );

  mikl_queue #(.Depth(Depth)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (push_job),
    .pop_i  (q_pop),
    .job_o  (pop_job),
    .stat_o (q_stat)
  );

  mikl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_i         (q_stat),
    .job_i       (pop_job),
    .pop_o       (q_pop),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

  `MIKL_ASSERT_IMPLIES(a_push_room, q_push, !q_stat.full, "item pushed into full queue")
  `MIKL_ASSERT_IMPLIES(a_pop_data, q_pop, !q_stat.empty, "item popped from empty queue")
  `MIKL_ASSERT_NEXT(a_zero_result, q_pop && pop_job.zero, result_valid_o && (result_o == '0),
                    "zero command did not give zero wheels")
endmodule

@@ hw/rtl/mikl_queue.sv @@
// Small item queue between the front and back parts.
module mikl_queue import mikl_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output job_t    job_o,
  output q_stat_t stat_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign job_o        = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

  function automatic logic [PtrW-1:0] nxt(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i)  rd_q <= nxt(rd_q);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule

@@ hw/rtl/mikl_front.sv @@
// Front part: accepts items, clamps the commands and flags all-zero ones.
module mikl_front import mikl_pkg::*; (
  input  logic start_i,
  input  cmd_t cmd_i,
  input  cfg_t cfg_i,
  input  logic full_i,
  output logic busy_o,
  output logic push_o,
  output job_t job_o
);
  function automatic logic signed [CmdW-1:0] clamp(logic signed [CmdW-1:0] v,
                                                    logic [CfgW-1:0] lim);
    logic signed [CmdW-1:0] l;
    l = $signed({1'b0, lim});
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    job_o.cmd.cmd_vx = clamp(cmd_i.cmd_vx, cfg_i.limit_vx);
    job_o.cmd.cmd_vy = clamp(cmd_i.cmd_vy, cfg_i.limit_vy);
    job_o.cmd.cmd_wz = clamp(cmd_i.cmd_wz, cfg_i.limit_wz);
    job_o.zero = (job_o.cmd.cmd_vx == '0) && (job_o.cmd.cmd_vy == '0) &&
                 (job_o.cmd.cmd_wz == '0);
  end
endmodule

@@ hw/rtl/mikl_back.sv @@
// Back part: wheel rate sequencer with four divider lanes and a scale divider.
module mikl_back import mikl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  q_stat_t q_i,
  input  job_t    job_i,
  output logic    pop_o,
  output logic    res_valid_o,
  output rate_t   res_o
);
  localparam int unsigned Lanes      = 4;
  localparam int unsigned DivCycles  = MagW / 2;
  localparam int unsigned SDivCycles = ScaleW / 2;
  localparam int unsigned CntW       = $clog2(DivCycles);
  localparam int unsigned CmpW       = CfgW + 31;
  localparam logic [MagW-1:0] MagCap = {MagW{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_KW, S_NUM, S_DIV, S_MAX, S_SDIV, S_SCALE, S_DONE
  } state_e;

  state_e                 state_q;
  logic                   pass_q, res_valid_q;
  rate_t                  res_q;
  logic signed [CmdW-1:0] vx_q, vy_q, wz_q;
  logic [MagW-1:0]        kw_q, mx_q;
  logic [AbsW-1:0]        a_q   [Lanes];
  logic                   neg_q [Lanes];
  logic                   ovf_q [Lanes];
  logic [RemW-1:0]        rem_q [Lanes];
  logic [MagW-1:0]        dvd_q [Lanes];
  logic [MagW-1:0]        quo_q [Lanes];
  logic [AbsW-1:0]        srem_q;
  logic [ScaleW-1:0]      s_q;
  logic [CntW-1:0]        cnt_q;
  logic [1:0]             sidx_q;

  logic [CmdW-1:0]        k, wz_mag, vsel_mag, mul_a, mul_b, scaled_mag;
  logic signed [CmdW-1:0] vsel, scaled;
  logic [2*CmdW-1:0]      prod;
  logic signed [NumW-1:0] kwn, vxe, vye;
  logic signed [NumW-1:0] n     [Lanes];
  logic [AbsW-1:0]        nmag  [Lanes];
  logic [RemW-1:0]        rem_nx [Lanes];
  logic [1:0]             qb    [Lanes];
  logic [MagW-1:0]        mag   [Lanes];
  logic [MagW-1:0]        mx01, mx23, mx;
  logic [AbsW-1:0]        srem_nx;
  logic [1:0]             sqb;

  function automatic logic [RemW:0] div_step(logic [RemW-1:0] r, logic b,
                                             logic [CfgW-1:0] d);
    logic [RemW-1:0] sh;
    sh = {r[RemW-2:0], b};
    if (sh >= {1'b0, d}) return {sh - {1'b0, d}, 1'b1};
    return {sh, 1'b0};
  endfunction

  function automatic logic [AbsW:0] sdiv_step(logic [AbsW-1:0] r, logic [MagW-1:0] d);
    logic [AbsW-1:0] sh;
    sh = {r[AbsW-2:0], 1'b0};
    if (sh >= {1'b0, d}) return {sh - {1'b0, d}, 1'b1};
    return {sh, 1'b0};
  endfunction

  function automatic logic signed [CmdW-1:0] sat(logic neg, logic [MagW-1:0] m);
    if (!neg) begin
      if (m > MagW'(32'h7fff_ffff)) return 32'sh7fff_ffff;
      return $signed(m[CmdW-1:0]);
    end
    if (m > MagW'(33'h1_0000_0000 >> 1)) return 32'sh8000_0000;
    return -$signed(m[CmdW-1:0]);
  endfunction

  always_comb begin
    logic [RemW:0] s1, s2;
    logic [AbsW:0] t1, t2;
    k      = {1'b0, cfg_i.half_length} + {1'b0, cfg_i.half_width};
    wz_mag = wz_q[CmdW-1] ? CmdW'(-wz_q) : CmdW'(wz_q);
    unique case (sidx_q)
      2'd0:    vsel = vx_q;
      2'd1:    vsel = vy_q;
      default: vsel = wz_q;
    endcase
    vsel_mag   = vsel[CmdW-1] ? CmdW'(-vsel) : CmdW'(vsel);
    mul_a      = (state_q == S_KW) ? k : vsel_mag;
    mul_b      = (state_q == S_KW) ? wz_mag : {{(CmdW-ScaleW){1'b0}}, s_q};
    prod       = mul_a * mul_b;
    scaled_mag = prod[ScaleW +: CmdW];
    scaled     = vsel[CmdW-1] ? -$signed(scaled_mag) : $signed(scaled_mag);

    kwn = $signed({2'b00, kw_q});
    if (wz_q[CmdW-1]) kwn = -kwn;
    vxe = NumW'(vx_q);
    vye = NumW'(vy_q);
    n[0] = vxe - vye - kwn;
    n[1] = vxe + vye + kwn;
    n[2] = vxe + vye - kwn;
    n[3] = vxe - vye + kwn;
    for (int i = 0; i < Lanes; i++) begin
      nmag[i]   = n[i][NumW-1] ? AbsW'(-n[i]) : AbsW'(n[i]);
      s1        = div_step(rem_q[i], dvd_q[i][MagW-1], cfg_i.wheel_dia);
      s2        = div_step(s1[RemW:1], dvd_q[i][MagW-2], cfg_i.wheel_dia);
      rem_nx[i] = s2[RemW:1];
      qb[i]     = {s1[0], s2[0]};
      mag[i]    = (a_q[i] == '0) ? '0 : (ovf_q[i] ? MagCap : quo_q[i]);
    end
    mx01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    mx23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
    mx   = (mx01 > mx23) ? mx01 : mx23;
    t1      = sdiv_step(srem_q, mx_q);
    t2      = sdiv_step(t1[AbsW:1], mx_q);
    srem_nx = t2[AbsW:1];
    sqb     = {t1[0], t2[0]};
  end

  assign pop_o       = (state_q == S_IDLE) && !q_i.empty;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (!q_i.empty) begin
            vx_q   <= job_i.cmd.cmd_vx;
            vy_q   <= job_i.cmd.cmd_vy;
            wz_q   <= job_i.cmd.cmd_wz;
            pass_q <= 1'b0;
            if (job_i.zero) begin
              res_q       <= '0;
              res_valid_q <= 1'b1;
            end else begin
              state_q <= S_KW;
            end
          end
        end
        S_KW: begin
          kw_q    <= prod[ScaleW +: MagW];
          state_q <= S_NUM;
        end
        S_NUM: begin
          for (int i = 0; i < Lanes; i++) begin
            a_q[i]   <= nmag[i];
            neg_q[i] <= n[i][NumW-1];
            // Quotient would not fit in the magnitude: saturate.
            ovf_q[i] <= (nmag[i] != '0) &&
                        (CmpW'(nmag[i]) >= {cfg_i.wheel_dia, 31'b0});
            rem_q[i] <= RemW'(nmag[i][AbsW-1:31]);
            dvd_q[i] <= {nmag[i][30:0], 17'b0};
          end
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          for (int i = 0; i < Lanes; i++) begin
            rem_q[i] <= rem_nx[i];
            dvd_q[i] <= dvd_q[i] << 2;
            quo_q[i] <= {quo_q[i][MagW-3:0], qb[i]};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DivCycles - 1)) begin
            state_q <= pass_q ? S_DONE : S_MAX;
          end
        end
        S_MAX: begin
          if (mx > MagW'(cfg_i.limit_wheel_rate)) begin
            mx_q    <= mx;
            srem_q  <= AbsW'(cfg_i.limit_wheel_rate);
            cnt_q   <= '0;
            state_q <= S_SDIV;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_SDIV: begin
          srem_q <= srem_nx;
          s_q    <= {s_q[ScaleW-3:0], sqb};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CntW'(SDivCycles - 1)) begin
            sidx_q  <= '0;
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          unique case (sidx_q)
            2'd0:    vx_q <= scaled;
            2'd1:    vy_q <= scaled;
            default: wz_q <= scaled;
          endcase
          if (sidx_q == 2'd2) begin
            pass_q  <= 1'b1;
            state_q <= S_KW;
          end else begin
            sidx_q <= sidx_q + 1'b1;
          end
        end
        S_DONE: begin
          res_q.rate_front_left  <= sat(neg_q[0], mag[0]);
          res_q.rate_front_right <= sat(neg_q[1], mag[1]);
          res_q.rate_back_left   <= sat(neg_q[2], mag[2]);
          res_q.rate_back_right  <= sat(neg_q[3], mag[3]);
          res_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
